>>> sv/arnp_pkg.sv
`timescale 1ns / 1ps
package arnp_pkg;

   localparam int unsigned VALUE_WIDTH_DEFAULT = 32;
   localparam int unsigned OUT_WIDTH           = 32;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_B = 8'h42;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_B = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;

   typedef enum logic [3:0] {
      PH_SEARCH = 4'b0001,
      PH_ZERO   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2
   } radix_type;

   typedef struct packed {
      phase_type phase;
      radix_type radix;
   } ctl_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   function automatic digit_type digit_decode(input logic [7:0] c, input radix_type rsel);
      digit_type d;
      logic [7:0] t;
      d = '{ok: 1'b0, val: 4'd0};
      t = 8'd0;
      case (rsel)
         RADIX_BIN: begin
            if (c == CHAR_ZERO || c == CHAR_ONE) begin
               d.ok  = 1'b1;
               d.val = c[3:0];
            end
         end
         RADIX_HEX: begin
            if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
               d.ok  = 1'b1;
               d.val = c[3:0];
            end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
               t     = c - CHAR_LOWER_A + 8'd10;
               d.ok  = 1'b1;
               d.val = t[3:0];
            end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
               t     = c - CHAR_UPPER_A + 8'd10;
               d.ok  = 1'b1;
               d.val = t[3:0];
            end
         end
         default: begin
            if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
               d.ok  = 1'b1;
               d.val = c[3:0];
            end
         end
      endcase
      return d;
   endfunction

endpackage

>>> sv/arnp_ifs.sv
`timescale 1ns / 1ps
interface arnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface arnp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        error;
   logic [1:0]  radix_code;

   modport source (output valid, output value, output error, output radix_code, input ready);
   modport sink   (input valid, input value, input error, input radix_code, output ready);
endinterface

>>> sv/arnp_step.sv
`timescale 1ns / 1ps
module arnp_step #(
   parameter int unsigned VALUE_WIDTH = arnp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  arnp_pkg::ctl_type        ctl_cur,
   input  logic [VALUE_WIDTH-1:0]   acc_cur,
   input  logic [7:0]               char_code,
   output arnp_pkg::ctl_type        ctl_nxt,
   output logic [VALUE_WIDTH-1:0]   acc_nxt
);

   arnp_pkg::digit_type    dig;
   logic [VALUE_WIDTH-1:0] dig_ext;
   logic [VALUE_WIDTH-1:0] mac;

   always_comb begin
      dig     = arnp_pkg::digit_decode(char_code, ctl_cur.radix);
      dig_ext = {{(VALUE_WIDTH-4){1'b0}}, dig.val};
      case (ctl_cur.radix)
         arnp_pkg::RADIX_HEX: mac = (acc_cur << 4) | dig_ext;
         arnp_pkg::RADIX_BIN: mac = (acc_cur << 1) | dig_ext;
         default:             mac = (acc_cur << 3) + (acc_cur << 1) + dig_ext;
      endcase
   end

   always_comb begin
      ctl_nxt = ctl_cur;
      acc_nxt = acc_cur;
      case (ctl_cur.phase)
         arnp_pkg::PH_SEARCH: begin
            if (char_code inside {[arnp_pkg::CHAR_ZERO:arnp_pkg::CHAR_NINE]}) begin
               acc_nxt       = {{(VALUE_WIDTH-4){1'b0}}, char_code[3:0]};
               ctl_nxt.radix = arnp_pkg::RADIX_DEC;
               ctl_nxt.phase = (char_code == arnp_pkg::CHAR_ZERO) ? arnp_pkg::PH_ZERO
                                                                  : arnp_pkg::PH_DIGITS;
            end
         end
         arnp_pkg::PH_ZERO: begin
            if (char_code == arnp_pkg::CHAR_LOWER_X || char_code == arnp_pkg::CHAR_UPPER_X) begin
               ctl_nxt.radix = arnp_pkg::RADIX_HEX;
               ctl_nxt.phase = arnp_pkg::PH_DIGITS;
            end else if (char_code == arnp_pkg::CHAR_LOWER_B
                         || char_code == arnp_pkg::CHAR_UPPER_B) begin
               ctl_nxt.radix = arnp_pkg::RADIX_BIN;
               ctl_nxt.phase = arnp_pkg::PH_DIGITS;
            end else if (char_code inside {[arnp_pkg::CHAR_ZERO:arnp_pkg::CHAR_NINE]}) begin
               acc_nxt       = {{(VALUE_WIDTH-4){1'b0}}, char_code[3:0]};
               ctl_nxt.phase = arnp_pkg::PH_DIGITS;
            end else begin
               ctl_nxt.phase = arnp_pkg::PH_DONE;
            end
         end
         arnp_pkg::PH_DIGITS: begin
            if (dig.ok) begin
               acc_nxt = mac;
            end else begin
               ctl_nxt.phase = arnp_pkg::PH_DONE;
            end
         end
         default: begin
            ctl_nxt = ctl_cur;
         end
      endcase
   end

endmodule

>>> sv/ascii_radix_number_parser.sv
`timescale 1ns / 1ps
// channel   dir  beat payload                     accepted when
// req_ch    in   char_code[7:0], last            valid && ready
// rsp_ch    out  value[31:0], error, radix_code  valid && ready
//
// One character per cycle, save one flagged last while a result is stalled:
// input register, one decode and multiply-add step, then parser state and result registers.
// A result is loaded into the result registers as its last character leaves the input register.
// Synchronous active-high reset clears valids and returns to the search phase.
// A stalled result holds only characters flagged last; others keep flowing.
module ascii_radix_number_parser #(
   parameter int unsigned VALUE_WIDTH = arnp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   arnp_req_if.sink           req_ch,
   arnp_rsp_if.source         rsp_ch
);

   localparam arnp_pkg::ctl_type CTL_RESET = '{phase: arnp_pkg::PH_SEARCH,
                                              radix: arnp_pkg::RADIX_DEC};

   logic                   s1_v_ff;
   logic [7:0]             s1_char_ff;
   logic                   s1_last_ff;
   logic                   s1_fire;
   logic                   req_take;

   arnp_pkg::ctl_type      ctl_ff, ctl_in, ctl_step;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in, acc_step;
   logic [VALUE_WIDTH+31:0] acc_ext;

   logic                   rsp_v_ff, rsp_v_in;
   logic [31:0]            rsp_value_ff, rsp_value_in;
   logic                   rsp_error_ff, rsp_error_in;
   arnp_pkg::radix_type    rsp_radix_ff, rsp_radix_in;
   logic                   rsp_load;

   arnp_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step (
      .ctl_cur   (ctl_ff),
      .acc_cur   (acc_ff),
      .char_code (s1_char_ff),
      .ctl_nxt   (ctl_step),
      .acc_nxt   (acc_step)
   );

   assign s1_fire   = s1_v_ff && (!s1_last_ff || !rsp_v_ff || rsp_ch.ready);
   assign req_take  = req_ch.valid && req_ch.ready;
   assign rsp_load  = s1_fire && s1_last_ff;
   assign acc_ext   = {32'd0, acc_step};

   assign req_ch.ready = !s1_v_ff || s1_fire;

   always_comb begin
      ctl_in       = ctl_ff;
      acc_in       = acc_ff;
      rsp_v_in     = rsp_v_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      rsp_radix_in = rsp_radix_ff;
      if (s1_fire) begin
         ctl_in = ctl_step;
         acc_in = acc_step;
      end
      if (rsp_load) begin
         rsp_v_in = 1'b1;
         if (ctl_step.phase == arnp_pkg::PH_SEARCH) begin
            rsp_value_in = '1;
            rsp_error_in = 1'b1;
            rsp_radix_in = arnp_pkg::RADIX_DEC;
         end else begin
            rsp_value_in = acc_ext[31:0];
            rsp_error_in = 1'b0;
            rsp_radix_in = ctl_step.radix;
         end
         ctl_in = CTL_RESET;
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
         ctl_ff   <= CTL_RESET;
         acc_ff   <= '0;
      end else begin
         if (req_take) begin
            s1_v_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_v_ff <= 1'b0;
         end
         rsp_v_ff <= rsp_v_in;
         ctl_ff   <= ctl_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_ch.char_code;
         s1_last_ff <= req_ch.last;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
      rsp_radix_ff <= rsp_radix_in;
   end

   assign rsp_ch.valid      = rsp_v_ff;
   assign rsp_ch.value      = rsp_value_ff;
   assign rsp_ch.error      = rsp_error_ff;
   assign rsp_ch.radix_code = rsp_radix_ff;

   a_state_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (ctl_ff.phase == arnp_pkg::PH_SEARCH) && (acc_ff == '0) && rsp_v_ff)
      else $error("parser state not cleared after end of string");

   a_last_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s1_last_ff && rsp_v_ff && !rsp_ch.ready)
      |=> s1_v_ff && s1_last_ff && $stable(s1_char_ff) && $stable(ctl_ff))
      else $error("end of string advanced over a stalled result");

   a_ready_only_when_free: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_v_ff && s1_last_ff && rsp_v_ff && !rsp_ch.ready))
      else $error("input stalled without a blocked result");

   a_error_payload: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) && rsp_error_ff |-> $past(ctl_step.phase) == arnp_pkg::PH_SEARCH
      && rsp_radix_ff == arnp_pkg::RADIX_DEC)
      else $error("error beat without an empty search");

endmodule
